@@ hdl/iapp_pkg.sv @@
// Shared types, widths and codes of the isochronous audio packet pacer.
`default_nettype none

package iapp_pkg;

  // Design limits on the ring and period sizes.
  localparam int unsigned RingBytesMax   = 65536;
  localparam int unsigned PeriodBytesMax = 4096;

  // Fixed field widths.
  localparam int unsigned LenW     = 12;
  localparam int unsigned OffOutW  = 16;
  localparam int unsigned AccW     = 22;
  localparam int unsigned ThrW     = 21;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgRingW = 17;
  localparam int unsigned CfgPerW  = 13;
  localparam int unsigned CfgPpsW  = 13;
  localparam int unsigned CfgFrmW  = 8;
  localparam int unsigned CfgStepW = 20;

  // Widths derived from the size limits.
  localparam int unsigned RingW = $clog2(RingBytesMax + 1);
  localparam int unsigned PtrW  = $clog2(RingBytesMax);
  localparam int unsigned PerW  = $clog2(PeriodBytesMax + 1);
  localparam int unsigned OffW  = $clog2(PeriodBytesMax);
  localparam int unsigned RSumW = ((PtrW > LenW) ? PtrW : LenW) + 1;
  localparam int unsigned PSumW = ((OffW > LenW) ? OffW : LenW) + 1;
  localparam int unsigned RemW  = (RSumW > PSumW) ? RSumW : PSumW;
  localparam int unsigned RemCntW = $clog2(RemW + 1);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgBasePacket = 3'd0,
    CfgResidueStep = 3'd1,
    CfgPacketsPerSec = 3'd2,
    CfgFrameBytes = 3'd3,
    CfgRingBytes = 3'd4,
    CfgPeriodBytes = 3'd5,
    CfgPlayback = 3'd6
  } cfg_idx_e;

  // Event kinds of an input transaction.
  typedef enum logic [2:0] {
    KindComplete = 3'd0,
    KindStart    = 3'd1,
    KindStop     = 3'd2,
    KindBadTrig  = 3'd3,
    KindEpOn     = 3'd4,
    KindEpOff    = 3'd5
  } kind_e;

  // Work handed from the sizing stage to the ring stage.
  typedef enum logic [1:0] {
    OpNone    = 2'd0,
    OpAdvance = 2'd1,
    OpClear   = 2'd2
  } s1_op_e;

  typedef struct packed {
    logic [2:0]      kind;
    logic [LenW-1:0] received_bytes;
    logic            link_shutdown;
  } in_item_t;

  typedef struct packed {
    logic [LenW-1:0]    packet_bytes;
    logic [OffOutW-1:0] ring_offset;
    logic [LenW-1:0]    first_bytes;
    logic [LenW-1:0]    wrap_bytes;
    logic               period_elapsed;
    logic               resubmit;
    logic               bad_command;
  } out_item_t;

  typedef struct packed {
    s1_op_e          op;
    logic [LenW-1:0] len;
    logic            resubmit;
    logic            bad_command;
  } s1_t;

endpackage

`default_nettype wire

@@ hdl/iapp_rem.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module iapp_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [iapp_pkg::RemW-1:0]  dividend_i,
  input  logic [iapp_pkg::RemW-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [iapp_pkg::RemW-1:0]  rem_o
);
  import iapp_pkg::*;

  logic               busy_q;
  logic [RemCntW-1:0] cnt_q;
  logic [RemW-1:0]    dvd_q;
  logic [RemW-1:0]    div_q;
  logic [RemW-1:0]    rem_q;
  logic [RemW:0]      trial;
  logic [RemW:0]      diff;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  assign trial = {rem_q, dvd_q[RemW-1]};
  assign diff  = trial - {1'b0, div_q};

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= RemCntW'(RemW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == RemCntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath; the remainder holds once the unit goes idle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_q <= diff[RemW-1:0];
      end else begin
        rem_q <= trial[RemW-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ hdl/iso_audio_packet_pacer.sv @@
// Top level of the isochronous audio packet pacer.
// Each input transaction is an event: a completion sizes a packet (playback: base size
// plus an extra frame when the residue accumulator reaches frame_bytes*packets_per_second;
// capture: the received byte count), splits it at the ring wrap, advances the ring pointer
// and reports a period crossing; triggers reset the ring position and start or stop the
// stream; endpoint events switch the endpoint and clear the residue. Every transaction
// yields exactly one result, registered first in the sizing stage and then in the output
// register once the output is free. The block takes one transaction per cycle as long as
// the output is not stalled and the new ring pointer and period offset each come out of a
// single subtraction of the ring or period size; when a packet wraps a very small ring or
// period more than once, the ring stage holds while a bit-serial remainder unit reduces
// the sums.
`default_nettype none

module iso_audio_packet_pacer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  iapp_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output iapp_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [iapp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [iapp_pkg::CfgDataW-1:0]   cfg_data_i
);
  import iapp_pkg::*;

  // Configuration registers.
  logic [LenW-1:0]     cfg_base_q;
  logic [CfgStepW-1:0] cfg_step_q;
  logic [CfgPpsW-1:0]  cfg_pps_q;
  logic [CfgFrmW-1:0]  cfg_frame_q;
  logic [CfgRingW-1:0] cfg_ring_q;
  logic [CfgPerW-1:0]  cfg_per_q;
  logic                cfg_play_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= '0;
      cfg_step_q  <= '0;
      cfg_pps_q   <= CfgPpsW'(1000);
      cfg_frame_q <= CfgFrmW'(4);
      cfg_ring_q  <= CfgRingW'(65536);
      cfg_per_q   <= CfgPerW'(4096);
      cfg_play_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgBasePacket:    cfg_base_q  <= cfg_data_i[LenW-1:0];
        CfgResidueStep:   cfg_step_q  <= cfg_data_i[CfgStepW-1:0];
        CfgPacketsPerSec: cfg_pps_q   <= cfg_data_i[CfgPpsW-1:0];
        CfgFrameBytes:    cfg_frame_q <= cfg_data_i[CfgFrmW-1:0];
        CfgRingBytes:     cfg_ring_q  <= CfgRingW'(cfg_data_i);
        CfgPeriodBytes:   cfg_per_q   <= cfg_data_i[CfgPerW-1:0];
        CfgPlayback:      cfg_play_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic      in_accept;
  logic      s1_valid_q;
  s1_t       s1_q;
  s1_t       s1_d;
  logic      s2_go;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t out_d;
  logic      out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_go;
  assign in_accept  = in_valid_i && in_ready_o;

  // Sizing stage: endpoint and stream state, residue accumulator.
  logic            stream_q, stream_d;
  logic            ep_q, ep_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [ThrW-1:0] thresh;
  logic [AccW-1:0] acc_sum;
  logic            extra_hit;
  logic [LenW:0]   play_sum;
  logic [LenW-1:0] play_len;

  assign thresh    = {{(ThrW-CfgFrmW){1'b0}}, cfg_frame_q} * {{(ThrW-CfgPpsW){1'b0}}, cfg_pps_q};
  assign acc_sum   = acc_q + AccW'(cfg_step_q);
  assign extra_hit = acc_sum >= AccW'(thresh);
  assign play_sum  = {1'b0, cfg_base_q} + (extra_hit ? (LenW+1)'(cfg_frame_q) : '0);
  assign play_len  = play_sum[LenW] ? '1 : play_sum[LenW-1:0];

  always_comb begin
    s1_d     = '{op: OpNone, len: '0, resubmit: 1'b0, bad_command: 1'b0};
    stream_d = stream_q;
    ep_d     = ep_q;
    acc_d    = acc_q;
    unique case (kind_e'(in_data_i.kind))
      KindComplete: begin
        if (ep_q && !in_data_i.link_shutdown) begin
          s1_d.resubmit = 1'b1;
          if (stream_q) begin
            s1_d.op = OpAdvance;
            if (cfg_play_q) begin
              s1_d.len = play_len;
              acc_d    = extra_hit ? (acc_sum - AccW'(thresh)) : acc_sum;
            end else begin
              s1_d.len = in_data_i.received_bytes;
            end
          end
        end
      end
      KindStart: begin
        s1_d.op  = OpClear;
        stream_d = 1'b1;
      end
      KindStop: begin
        s1_d.op  = OpClear;
        stream_d = 1'b0;
      end
      KindBadTrig: begin
        s1_d.op          = OpClear;
        s1_d.bad_command = 1'b1;
      end
      KindEpOn: begin
        ep_d  = 1'b1;
        acc_d = '0;
      end
      KindEpOff: begin
        ep_d  = 1'b0;
        acc_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q   <= 1'b0;
      ep_q       <= 1'b0;
      acc_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        stream_q <= stream_d;
        ep_q     <= ep_d;
        acc_q    <= acc_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  // Ring stage: effective sizes and the clamped pointer.
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [RingW-1:0] ring_eff;
  logic [PerW-1:0]  per_eff;
  logic [PtrW-1:0]  ptr;
  logic [RingW-1:0] space;
  logic [LenW-1:0]  first;

  assign ring_eff = ((cfg_ring_q == '0) || (32'(cfg_ring_q) > 32'(RingBytesMax)))
                    ? RingW'(RingBytesMax) : RingW'(cfg_ring_q);
  assign per_eff  = ((cfg_per_q == '0) || (32'(cfg_per_q) > 32'(PeriodBytesMax)))
                    ? PerW'(PeriodBytesMax) : PerW'(cfg_per_q);
  assign ptr      = (32'(ptr_q) >= 32'(ring_eff)) ? '0 : ptr_q;
  assign space    = ring_eff - RingW'(ptr);
  assign first    = (32'(space) > 32'(s1_q.len)) ? s1_q.len : LenW'(space);

  // Single-subtraction reduction of the new pointer and period offset.
  logic [RSumW-1:0] rsum, rdiff, ring_ext;
  logic [PSumW-1:0] psum, pdiff, per_ext;
  logic             r_ge, p_ge, r_fast, p_fast, fast;

  assign ring_ext = RSumW'(ring_eff);
  assign per_ext  = PSumW'(per_eff);
  assign rsum     = RSumW'(ptr) + RSumW'(s1_q.len);
  assign psum     = PSumW'(off_q) + PSumW'(s1_q.len);
  assign rdiff    = rsum - ring_ext;
  assign pdiff    = psum - per_ext;
  assign r_ge     = rsum >= ring_ext;
  assign p_ge     = psum >= per_ext;
  assign r_fast   = !r_ge || (rdiff < ring_ext);
  assign p_fast   = !p_ge || (pdiff < per_ext);
  assign fast     = r_fast && p_fast;

  // Remainder units for the rare multiple-wrap case.
  logic            rem_wait_q;
  logic            rem_start;
  logic            rem_ring_busy, rem_per_busy;
  logic [RemW-1:0] rem_ring, rem_per;
  logic            rem_done;
  logic            adv;

  assign adv       = s1_valid_q && (s1_q.op == OpAdvance);
  assign rem_start = adv && !fast && !rem_wait_q;
  assign rem_done  = rem_wait_q && !rem_ring_busy && !rem_per_busy;
  assign s2_go     = s1_valid_q && out_free && (!adv || fast || rem_done);

  iapp_rem u_rem_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (RemW'(rsum)),
    .divisor_i  (RemW'(ring_ext)),
    .busy_o     (rem_ring_busy),
    .rem_o      (rem_ring)
  );

  iapp_rem u_rem_per (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (RemW'(psum)),
    .divisor_i  (RemW'(per_ext)),
    .busy_o     (rem_per_busy),
    .rem_o      (rem_per)
  );

  // Result and next ring state.
  always_comb begin
    out_d = '0;
    ptr_d = ptr_q;
    off_d = off_q;
    out_d.resubmit    = s1_q.resubmit;
    out_d.bad_command = s1_q.bad_command;
    unique case (s1_q.op)
      OpAdvance: begin
        out_d.packet_bytes   = s1_q.len;
        out_d.ring_offset    = OffOutW'(ptr);
        out_d.first_bytes    = first;
        out_d.wrap_bytes     = s1_q.len - first;
        out_d.period_elapsed = p_ge;
        if (fast) begin
          ptr_d = r_ge ? PtrW'(rdiff) : PtrW'(rsum);
          off_d = p_ge ? OffW'(pdiff) : OffW'(psum);
        end else begin
          ptr_d = PtrW'(rem_ring);
          off_d = OffW'(rem_per);
        end
      end
      OpClear: begin
        ptr_d = '0;
        off_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      off_q       <= '0;
      rem_wait_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rem_start) begin
        rem_wait_q <= 1'b1;
      end else if (s2_go) begin
        rem_wait_q <= 1'b0;
      end
      if (s2_go) begin
        ptr_q <= ptr_d;
        off_q <= off_d;
      end
      if (out_free) begin
        out_valid_q <= s2_go;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/iapp_checker.sv @@
// Port-level checks of the packet pacer and their binding to the top level.
`default_nettype none

module iapp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input iapp_pkg::out_item_t out_data_o
);
  import iapp_pkg::*;

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // The two copy segments cover the packet exactly.
  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (13'(out_data_o.first_bytes) + 13'(out_data_o.wrap_bytes)
                     == 13'(out_data_o.packet_bytes)))
    else $error("ring split does not add up to the packet size");

  // An unknown trigger moves no data and queues nothing.
  a_bad_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_command |->
      (out_data_o.packet_bytes == '0) && !out_data_o.resubmit && !out_data_o.period_elapsed)
    else $error("unknown trigger produced a transfer");

  // A period crossing only comes with a queued request.
  a_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.period_elapsed |-> out_data_o.resubmit)
    else $error("period crossing without resubmission");

endmodule

bind iso_audio_packet_pacer iapp_checker u_iapp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
